// ----- hw/rtl/rsbsk_pkg.sv -----
package rsbsk_pkg;

    localparam int KEY_W            = 64;
    localparam int TAG_W            = 7;
    localparam int DEF_RECORD_COUNT = 64;
    localparam int DEF_KEY_BYTES    = 8;

    // input commands
    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_SORT = 1'b1
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        ST_RECORD = 2'd0,
        ST_LOADED = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // operation broadcast to every cell of the row
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_LOAD   = 2'd1,
        CELL_SORT   = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_op;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SORT = 2'd1,
        S_EMIT = 2'd2
    } t_state;

    // one stored record
    typedef struct packed {
        logic [KEY_W-1:0] name_key;
        logic [KEY_W-1:0] address_key;
        logic [TAG_W-1:0] tag;
    } t_rec;

    // row control shared by all cells
    typedef struct packed {
        t_cell_op op;
        logic     phase;       // odd/even transposition phase
        logic     sort_field;  // 0 name key, 1 address key
    } t_cell_ctl;

endpackage

// ----- hw/rtl/record_sort_by_string_key.sv -----
// Record store and sorter. Load beats (cmd 0) append one record to a row of
// RECORD_COUNT cells; a full store answers status 2 and drops the record. A
// sort beat (cmd 1) runs an odd-even transposition sort in the cell row, one
// exchange phase per cycle for n phases (n = records held), ordering stably and
// ascending on the top KEY_BYTES bytes of the key chosen by sort_field, then
// emits the n records in order by rotating the row through cell 0, one beat
// per cycle unless the output stalls, with last on the final one. An empty
// store answers one status 3 beat. The sorted order stays in the store. The
// user must write sort_field only while the block is idle (not enforced).
module record_sort_by_string_key #(
    parameter int RECORD_COUNT = rsbsk_pkg::DEF_RECORD_COUNT,
    parameter int KEY_BYTES    = rsbsk_pkg::DEF_KEY_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_cmd,
    input  logic [rsbsk_pkg::KEY_W-1:0] i_name_key,
    input  logic [rsbsk_pkg::KEY_W-1:0] i_address_key,
    input  logic [rsbsk_pkg::TAG_W-1:0] i_record_tag,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_status,
    output logic [rsbsk_pkg::KEY_W-1:0] o_out_name_key,
    output logic [rsbsk_pkg::KEY_W-1:0] o_out_address_key,
    output logic [rsbsk_pkg::TAG_W-1:0] o_out_tag,
    output logic                        o_last
);
    import rsbsk_pkg::*;

    localparam int CNT_W = $clog2(RECORD_COUNT + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RECORD_COUNT);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_step;
    logic [CNT_W-1:0] n_step;
    logic             r_sort_field;
    logic             r_out_valid;
    logic             n_out_valid;
    t_status          r_status;
    t_status          n_status;
    t_rec             r_out_rec;
    t_rec             n_out_rec;
    logic             r_last;
    logic             n_last;

    logic             out_free;
    logic             in_beat;
    t_cell_ctl        ctl;
    t_rec             load_rec;
    t_rec             cell_rec  [RECORD_COUNT];
    logic             cell_swap [RECORD_COUNT];

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_beat    = i_in_valid && o_in_ready;

    assign load_rec.name_key    = i_name_key;
    assign load_rec.address_key = i_address_key;
    assign load_rec.tag         = i_record_tag;

    // sequencer: next state, row operation and output register load
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_out_rec   = r_out_rec;
        n_last      = r_last;
        ctl.op         = CELL_HOLD;
        ctl.phase      = r_step[0];
        ctl.sort_field = r_sort_field;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_out_valid = 1'b1;
                    n_out_rec   = '0;
                    n_last      = 1'b1;
                    if (t_cmd'(i_cmd) == CMD_LOAD) begin
                        if (r_count == FULL_CNT) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status = ST_LOADED;
                            ctl.op   = CELL_LOAD;
                            n_count  = r_count + 1'b1;
                        end
                    end else if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_out_valid = 1'b0;
                        n_step      = '0;
                        n_state     = S_SORT;
                    end
                end
            end
            S_SORT: begin
                ctl.op = CELL_SORT;
                if (r_step == r_count - 1'b1) begin
                    n_step  = '0;
                    n_state = S_EMIT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    ctl.op      = CELL_ROTATE;
                    n_out_valid = 1'b1;
                    n_status    = ST_RECORD;
                    n_out_rec   = cell_rec[0];
                    n_last      = (r_step == r_count - 1'b1);
                    n_step      = r_step + 1'b1;
                    if (r_step == r_count - 1'b1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_step       <= '0;
            r_sort_field <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_sort_field <= i_cfg_data;
            end
        end
    end

    // output beat payload
    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_out_rec <= n_out_rec;
        r_last    <= n_last;
    end

    // row of record cells
    for (genvar g = 0; g < RECORD_COUNT; g++) begin : g_cell
        rsbsk_cell #(
            .IDX       (g),
            .CNT_W     (CNT_W),
            .KEY_BYTES (KEY_BYTES)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_count     (r_count),
            .i_load      (load_rec),
            .i_left      (cell_rec[(g == 0) ? 0 : g - 1]),
            .i_swap_left ((g == 0) ? 1'b0 : cell_swap[(g == 0) ? 0 : g - 1]),
            .i_right     (cell_rec[(g == RECORD_COUNT - 1) ? 0 : g + 1]),
            .i_wrap      (cell_rec[0]),
            .o_rec       (cell_rec[g]),
            .o_swap      (cell_swap[g])
        );
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_out_name_key    = r_out_rec.name_key;
    assign o_out_address_key = r_out_rec.address_key;
    assign o_out_tag         = r_out_rec.tag;
    assign o_last            = r_last;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("record count above store size");

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_step < r_count))
        else $error("emit index beyond stored records");

    a_load_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && t_cmd'(i_cmd) == CMD_LOAD && r_count != FULL_CNT)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted load did not advance the count");

    a_last_ends_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free && r_step == r_count - 1'b1)
        |=> (r_state == S_IDLE && r_out_valid && r_last))
        else $error("final record beat did not close the sort");

    a_sort_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SORT) |-> (r_count != '0))
        else $error("sort running on an empty store");

endmodule

// ----- hw/rtl/rsbsk_cell.sv -----
module rsbsk_cell #(
    parameter int IDX       = 0,
    parameter int CNT_W     = 7,
    parameter int KEY_BYTES = 8
) (
    input  logic                i_clk,
    input  rsbsk_pkg::t_cell_ctl i_ctl,
    input  logic [CNT_W-1:0]    i_count,
    input  rsbsk_pkg::t_rec     i_load,
    input  rsbsk_pkg::t_rec     i_left,
    input  logic                i_swap_left,
    input  rsbsk_pkg::t_rec     i_right,
    input  rsbsk_pkg::t_rec     i_wrap,
    output rsbsk_pkg::t_rec     o_rec,
    output logic                o_swap
);
    import rsbsk_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX   = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] NEXT_IDX = CNT_W'(IDX + 1);
    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} << (8 * (8 - KEY_BYTES));

    t_rec             r_rec;
    t_rec             n_rec;
    logic             is_left;
    logic             pair_active;
    logic [KEY_W-1:0] my_key;
    logic [KEY_W-1:0] right_key;

    // role in the current phase: left member compares against its right neighbor
    assign is_left     = (MY_IDX[0] == i_ctl.phase);
    assign pair_active = (NEXT_IDX < i_count);

    assign my_key    = (i_ctl.sort_field ? r_rec.address_key : r_rec.name_key) & KEY_MASK;
    assign right_key = (i_ctl.sort_field ? i_right.address_key : i_right.name_key) & KEY_MASK;

    // strict compare keeps equal keys in load order
    assign o_swap = (i_ctl.op == CELL_SORT) && is_left && pair_active && (my_key > right_key);

    always_comb begin
        n_rec = r_rec;
        case (i_ctl.op)
            CELL_LOAD: begin
                if (i_count == MY_IDX) begin
                    n_rec = i_load;
                end
            end
            CELL_SORT: begin
                if (o_swap) begin
                    n_rec = i_right;
                end else if (!is_left && i_swap_left) begin
                    n_rec = i_left;
                end
            end
            CELL_ROTATE: begin
                // last occupied cell takes the head record
                n_rec = (i_count == NEXT_IDX) ? i_wrap : i_right;
            end
            default: begin
                n_rec = r_rec;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec = r_rec;

endmodule

// ----- tb/sv/record_sort_by_string_key_tb.sv -----
`timescale 1ns / 1ps

module record_sort_by_string_key_tb;
    import rsbsk_pkg::*;

    localparam int REC_MAX       = DEF_RECORD_COUNT;
    localparam int KEY_LEN       = DEF_KEY_BYTES;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 2 * REC_MAX + 20;

    // one input beat as the driver presents it
    typedef struct {
        t_cmd             cmd;
        logic [KEY_W-1:0] name_key;
        logic [KEY_W-1:0] address_key;
        logic [TAG_W-1:0] tag;
    } t_cmd_beat;

    // one expected output beat
    typedef struct {
        t_status          status;
        logic [KEY_W-1:0] name_key;
        logic [KEY_W-1:0] address_key;
        logic [TAG_W-1:0] tag;
        logic             last;
    } t_outcome;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             cfg_we        = 1'b0;
    logic             cfg_data      = 1'b0;
    logic             in_valid      = 1'b0;
    logic             in_ready;
    logic             in_cmd        = 1'b0;
    logic [KEY_W-1:0] in_name_key   = '0;
    logic [KEY_W-1:0] in_address_key = '0;
    logic [TAG_W-1:0] in_tag        = '0;
    logic             out_valid;
    logic             out_ready     = 1'b0;
    logic [1:0]       out_status;
    logic [KEY_W-1:0] out_name_key;
    logic [KEY_W-1:0] out_address_key;
    logic [TAG_W-1:0] out_tag;
    logic             out_last;

    // commands waiting to be driven, results waiting to arrive
    t_cmd_beat cmd_queue[$];
    t_outcome  awaited_q[$];
    t_cmd_beat cur_beat;

    // mirror of the store
    t_rec rec_store[REC_MAX];
    int   rec_count;
    logic order_by_addr;

    int   in_gap;
    int   out_gap;
    bit   quiet;
    int   stall_cycles;
    int   mismatches;
    int   beats_checked;
    int   n_loaded;
    int   n_full;
    int   n_sorts;
    int   n_empty;
    int   n_records;

    always #6 clk = ~clk;

    record_sort_by_string_key #(
        .RECORD_COUNT (REC_MAX),
        .KEY_BYTES    (KEY_LEN)
    ) dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_cmd             (in_cmd),
        .i_name_key        (in_name_key),
        .i_address_key     (in_address_key),
        .i_record_tag      (in_tag),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_status          (out_status),
        .o_out_name_key    (out_name_key),
        .o_out_address_key (out_address_key),
        .o_out_tag         (out_tag),
        .o_last            (out_last)
    );

    // only the top KEY_LEN bytes take part in ordering
    function automatic logic [KEY_W-1:0] order_key(input t_rec r);
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] mask;
        k    = order_by_addr ? r.address_key : r.name_key;
        mask = (KEY_LEN >= 8) ? '1 : ({KEY_W{1'b1}} << (8 * (8 - KEY_LEN)));
        return k & mask;
    endfunction

    task automatic push_outcome(input t_status st, input logic [KEY_W-1:0] nk,
                                input logic [KEY_W-1:0] ak, input logic [TAG_W-1:0] tg,
                                input logic lst);
        t_outcome o;
        o.status      = st;
        o.name_key    = nk;
        o.address_key = ak;
        o.tag         = tg;
        o.last        = lst;
        awaited_q.push_back(o);
    endtask

    // apply one accepted command to the mirror and queue its results
    task automatic apply_cmd(input t_cmd_beat b);
        t_rec tmp;
        int   i;
        int   j;
        if (b.cmd == CMD_LOAD) begin
            if (rec_count >= REC_MAX) begin
                n_full++;
                push_outcome(ST_FULL, '0, '0, '0, 1'b1);
            end else begin
                rec_store[rec_count].name_key    = b.name_key;
                rec_store[rec_count].address_key = b.address_key;
                rec_store[rec_count].tag         = b.tag;
                rec_count++;
                n_loaded++;
                push_outcome(ST_LOADED, '0, '0, '0, 1'b1);
            end
        end else begin
            n_sorts++;
            if (rec_count == 0) begin
                n_empty++;
                push_outcome(ST_EMPTY, '0, '0, '0, 1'b1);
            end else begin
                // stable bubble sort, swap only on strictly greater
                for (i = 0; i + 1 < rec_count; i++) begin
                    for (j = 0; j + 1 < rec_count - i; j++) begin
                        if (order_key(rec_store[j]) > order_key(rec_store[j + 1])) begin
                            tmp              = rec_store[j];
                            rec_store[j]     = rec_store[j + 1];
                            rec_store[j + 1] = tmp;
                        end
                    end
                end
                for (i = 0; i < rec_count; i++) begin
                    push_outcome(ST_RECORD, rec_store[i].name_key,
                                 rec_store[i].address_key, rec_store[i].tag,
                                 (i + 1 == rec_count));
                end
                n_records += rec_count;
            end
        end
    endtask

    task automatic note_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic queue_cmd(input t_cmd c, input logic [KEY_W-1:0] nk,
                             input logic [KEY_W-1:0] ak, input logic [TAG_W-1:0] tg);
        t_cmd_beat b;
        b.cmd         = c;
        b.name_key    = nk;
        b.address_key = ak;
        b.tag         = tg;
        cmd_queue.push_back(b);
    endtask

    // keys with many duplicates, shared prefixes, NULs and 0xFF bytes
    function automatic logic [KEY_W-1:0] make_key();
        logic [KEY_W-1:0] k;
        int               len;
        int               i;
        k = '0;
        case ($urandom_range(0, 3))
            0: k = {$urandom, $urandom};
            1: begin
                len = $urandom_range(0, 8);
                for (i = 0; i < len; i++)
                    k[KEY_W-1-8*i -: 8] = 8'h41 + 8'($urandom_range(0, 2));
            end
            2: begin
                for (i = 0; i < 8; i++) begin
                    case ($urandom_range(0, 3))
                        0: k[KEY_W-1-8*i -: 8] = 8'h00;
                        1: k[KEY_W-1-8*i -: 8] = 8'h41;
                        2: k[KEY_W-1-8*i -: 8] = 8'h42;
                        default: k[KEY_W-1-8*i -: 8] = 8'hFF;
                    endcase
                end
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: k = 64'h4142_0000_0000_0000;
                    1: k = 64'h4142_4300_0000_0000;
                    2: k = 64'h0;
                    default: k = '1;
                endcase
            end
        endcase
        return k;
    endfunction

    task automatic queue_random(input int count, input int sort_pct);
        int   i;
        t_cmd c;
        for (i = 0; i < count; i++) begin
            c = ($urandom_range(0, 99) < sort_pct) ? CMD_SORT : CMD_LOAD;
            queue_cmd(c, make_key(), make_key(), TAG_W'($urandom_range(0, 127)));
        end
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || in_valid || awaited_q.size() != 0)
            @(posedge clk);
    endtask

    // sort_field may change only with the block idle
    task automatic settle_and_config(input logic field);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= field;
        @(posedge clk);
        cfg_we   <= 1'b0;
        order_by_addr = field;
    endtask

    // input driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                apply_cmd(cur_beat);
            if (!in_valid || in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (cmd_queue.size() != 0) begin
                    cur_beat       = cmd_queue.pop_front();
                    in_cmd         <= cur_beat.cmd;
                    in_name_key    <= cur_beat.name_key;
                    in_address_key <= cur_beat.address_key;
                    in_tag         <= cur_beat.tag;
                    in_valid       <= 1'b1;
                    if (!quiet && $urandom_range(0, 7) == 0)
                        in_gap = $urandom_range(1, 5);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and checker
    always @(posedge clk) begin
        t_outcome exp_o;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                beats_checked++;
                if (awaited_q.size() == 0) begin
                    note_mismatch($sformatf("beat with nothing awaited, status %0d",
                                            out_status));
                end else begin
                    exp_o = awaited_q.pop_front();
                    if (out_status !== exp_o.status)
                        note_mismatch($sformatf("status %0d, want %0d",
                                                out_status, exp_o.status));
                    if (out_name_key !== exp_o.name_key)
                        note_mismatch($sformatf("name key %h, want %h",
                                                out_name_key, exp_o.name_key));
                    if (out_address_key !== exp_o.address_key)
                        note_mismatch($sformatf("address key %h, want %h",
                                                out_address_key, exp_o.address_key));
                    if (out_tag !== exp_o.tag)
                        note_mismatch($sformatf("tag %0d, want %0d", out_tag, exp_o.tag));
                    if (out_last !== exp_o.last)
                        note_mismatch($sformatf("last %b, want %b", out_last, exp_o.last));
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0)
                    out_gap = $urandom_range(1, 5);
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", stall_cycles);
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        rec_count     = 0;
        order_by_addr = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        settle_and_config(1'b0);

        // directed: empty store, single record, key extremes, prefixes,
        // embedded NULs and equal keys
        queue_cmd(CMD_SORT, '0, '0, '0);
        queue_cmd(CMD_LOAD, 64'h4200_0000_0000_0000, 64'h4142_0000_0000_0000, 7'd1);
        queue_cmd(CMD_SORT, '1, '1, '1);
        queue_cmd(CMD_LOAD, '1, '0, 7'd127);
        queue_cmd(CMD_LOAD, '0, '1, 7'd0);
        queue_cmd(CMD_LOAD, 64'h4142_0000_0000_0000, 64'h5A00_0000_0000_0000, 7'd2);
        queue_cmd(CMD_LOAD, 64'h4142_4300_0000_0000, 64'h5900_0000_0000_0000, 7'd3);
        queue_cmd(CMD_LOAD, 64'h4142_0000_0000_0000, 64'h5A00_0000_0000_0000, 7'd4);
        queue_cmd(CMD_LOAD, 64'h4100_4300_0000_0000, 64'h4142_0000_0000_0000, 7'd5);
        queue_cmd(CMD_LOAD, 64'h4100_4200_0000_0000, 64'h4100_0000_0000_0000, 7'd6);
        queue_cmd(CMD_LOAD, '0, 64'h0000_0000_0000_0001, 7'd7);
        queue_cmd(CMD_LOAD, 64'h4200_0000_0000_0000, 64'h4100_0000_0000_0000, 7'd8);
        queue_cmd(CMD_SORT, '0, '0, '0);
        settle_and_config(1'b1);
        queue_cmd(CMD_SORT, '0, '0, '0);
        queue_cmd(CMD_LOAD, 64'h4300_0000_0000_0000, 64'h4142_0000_0000_0001, 7'd9);
        queue_cmd(CMD_SORT, '0, '0, '0);

        // random phases; the store fills and later loads are refused
        settle_and_config(1'b0);
        queue_random(40, 15);
        settle_and_config(1'b1);
        queue_random(40, 15);
        settle_and_config(1'b0);
        queue_random(40, 20);
        settle_and_config(1'b1);
        quiet = 1'b1;
        queue_random(35, 20);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d loads, %0d refused as full, %0d sorts (%0d on empty store)",
                 n_loaded, n_full, n_sorts, n_empty);
        $display("%0d records emitted, %0d result beats checked, %0d mismatches",
                 n_records, beats_checked, mismatches);
        if (mismatches == 0 && awaited_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
